// File: rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg: shared definitions for the marked frame deframer
// Widths, register indexes, reset values and the command/status bundles
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package mfd_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int IDX_W       = 6;
   localparam int BUF_DEPTH   = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int STATE_W     = 3;

   // largest payload the buffer is sized for
   localparam logic [LEN_W-1:0] MAX_PAYLOAD = LEN_W'(62);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MARK_BYTE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH = CSR_INDEX_W'(1);

   // register reset values
   localparam logic [BYTE_W-1:0] MARK_BYTE_RESET  = BYTE_W'(126);
   localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET = LEN_W'(62);

   // controller to datapath
   typedef struct packed {
      logic load_len;   // take the length byte, restart the buffer
      logic buf_write;  // store a data or check byte
      logic rd_start;   // start replay at slot zero
      logic rd_next;    // advance replay slot
      logic out_data;   // load output register with replay byte
      logic out_drop;   // load output register with a dropped-frame result
   } mfd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_mark;    // input byte equals the mark
      logic len_ok;     // input byte is a usable length
      logic rem_le1;    // at most one data byte left
      logic out_free;   // output register can take a result this cycle
      logic rd_last;    // current replay slot is the check byte
   } mfd_status_type;

endpackage

// File: rtl/marked_frame_deframer.sv
// ----------------------------------------------------------------------------
// marked_frame_deframer: byte-serial marked frame parser
// Bytes enter on the req_ channel, one per transaction. Frames are
// start mark, length, data bytes, check byte, end mark. The length must
// differ from the mark and not exceed max_length (capped at 62); a zero
// length still takes one data byte.
// On a good end mark the buffered data bytes and then the check byte come
// out on the rsp_ channel, rsp_last on the check byte. A bad end mark gives
// one result with rsp_status set. Parsing bytes are taken one per
// transaction; after the end mark each result is replayed as a buffer
// read, then an output load, and req_stall is high for the whole replay.
// One output register sits on the rsp_ side; a stalled result holds there.
// An end mark is held off while that register is full and stalled; other
// bytes keep flowing.
// csr_ writes (index 0 mark_byte, 1 max_length) are taken at once.
// Synchronous reset restores mark 126, max_length 62, and waits for a
// start mark; the frame buffer is not cleared.
// ----------------------------------------------------------------------------
module marked_frame_deframer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mfd_pkg::BYTE_W-1:0]      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mfd_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_is_check,
   output logic [mfd_pkg::LEN_W-1:0]       rsp_frame_length,
   output logic                            rsp_status,
   output logic                            rsp_last
);
   import mfd_pkg::*;

   mfd_cmd_type    cmd;
   mfd_status_type status;

   // sequencer
   mfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, buffer and output stage
   mfd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_check     (rsp_is_check),
      .rsp_frame_length (rsp_frame_length),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// File: rtl/mfd_ctrl.sv
// ----------------------------------------------------------------------------
// mfd_ctrl: frame parse and replay sequencer
// Walks the frame layout one byte per transaction, then steps the buffer
// replay one result at a time into the output register.
// ----------------------------------------------------------------------------
module mfd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mfd_pkg::mfd_status_type status,
   output mfd_pkg::mfd_cmd_type    cmd
);
   import mfd_pkg::*;

   localparam logic [STATE_W-1:0] ST_START  = 3'd0;
   localparam logic [STATE_W-1:0] ST_LENGTH = 3'd1;
   localparam logic [STATE_W-1:0] ST_DATA   = 3'd2;
   localparam logic [STATE_W-1:0] ST_CHECK  = 3'd3;
   localparam logic [STATE_W-1:0] ST_END    = 3'd4;
   localparam logic [STATE_W-1:0] ST_READ   = 3'd5;
   localparam logic [STATE_W-1:0] ST_LOAD   = 3'd6;

   logic [STATE_W-1:0] state_ff;
   logic [STATE_W-1:0] state_in;
   logic               accept;

   // no input during replay; the end mark waits for a free output slot
   assign req_stall = (state_ff == ST_READ) || (state_ff == ST_LOAD) ||
                      ((state_ff == ST_END) && !status.out_free);
   assign accept    = req_valid && !req_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_START: begin
            if (accept && status.is_mark) state_in = ST_LENGTH;
         end
         ST_LENGTH: begin
            if (accept && status.len_ok) begin
               cmd.load_len = 1'b1;
               state_in     = ST_DATA;
            end
         end
         ST_DATA: begin
            if (accept) begin
               cmd.buf_write = 1'b1;
               if (status.rem_le1) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (accept) begin
               cmd.buf_write = 1'b1;
               state_in      = ST_END;
            end
         end
         ST_END: begin
            if (accept) begin
               if (status.is_mark) begin
                  cmd.rd_start = 1'b1;
                  state_in     = ST_READ;
               end else begin
                  cmd.out_drop = 1'b1;
                  state_in     = ST_START;
               end
            end
         end
         ST_READ: begin
            // buffer read in flight
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.out_data = 1'b1;
               cmd.rd_next  = 1'b1;
               state_in     = status.rd_last ? ST_START : ST_READ;
            end
         end
         default: begin
            state_in = ST_START;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/mfd_dp.sv
// ----------------------------------------------------------------------------
// mfd_dp: deframer datapath
// Configuration registers, length and index counters, the frame buffer
// and the result output register.
// ----------------------------------------------------------------------------
module mfd_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mfd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [mfd_pkg::BYTE_W-1:0]          req_in_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mfd_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic                                rsp_is_check,
   output logic [mfd_pkg::LEN_W-1:0]           rsp_frame_length,
   output logic                                rsp_status,
   output logic                                rsp_last,
   input  mfd_pkg::mfd_cmd_type                cmd,
   output mfd_pkg::mfd_status_type             status
);
   import mfd_pkg::*;

   logic [BYTE_W-1:0] mark_ff;
   logic [LEN_W-1:0]  max_len_ff;
   logic [LEN_W-1:0]  limit;

   logic [LEN_W-1:0]  rem_ff,  rem_in;
   logic [LEN_W-1:0]  held_ff, held_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   logic [BYTE_W-1:0] buf_mem [BUF_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff,  out_byte_in;
   logic              out_check_ff, out_check_in;
   logic [LEN_W-1:0]  out_len_ff,   out_len_in;
   logic              out_stat_ff,  out_stat_in;
   logic              out_last_ff,  out_last_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff    <= MARK_BYTE_RESET;
         max_len_ff <= MAX_LENGTH_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MARK_BYTE)  mark_ff    <= csr_wdata[BYTE_W-1:0];
         if (csr_index == CSR_MAX_LENGTH) max_len_ff <= csr_wdata[LEN_W-1:0];
      end
   end

   // status to the controller
   assign limit           = (max_len_ff > MAX_PAYLOAD) ? MAX_PAYLOAD : max_len_ff;
   assign status.is_mark  = (req_in_byte == mark_ff);
   assign status.len_ok   = !status.is_mark &&
                            (req_in_byte <= {{(BYTE_W-LEN_W){1'b0}}, limit});
   assign status.rem_le1  = (rem_ff <= LEN_W'(1));
   assign status.out_free = !out_valid_ff || !rsp_stall;
   assign status.rd_last  = (IDX_W'(rd_idx_ff + 1'b1) == wr_idx_ff);

   // counters
   always_comb begin
      rem_in    = rem_ff;
      held_in   = held_ff;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.load_len) begin
         held_in   = req_in_byte[LEN_W-1:0];
         rem_in    = req_in_byte[LEN_W-1:0];
         wr_idx_in = '0;
      end
      if (cmd.buf_write) begin
         wr_idx_in = IDX_W'(wr_idx_ff + 1'b1);
         rem_in    = status.rem_le1 ? '0 : LEN_W'(rem_ff - 1'b1);
      end
      if (cmd.rd_start) rd_idx_in = '0;
      if (cmd.rd_next)  rd_idx_in = IDX_W'(rd_idx_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         held_ff   <= '0;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else begin
         rem_ff    <= rem_in;
         held_ff   <= held_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   // frame buffer: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.buf_write) buf_mem[wr_idx_ff] <= req_in_byte;
      rd_data_ff <= buf_mem[rd_idx_ff];
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_check_in = out_check_ff;
      out_len_in   = out_len_ff;
      out_stat_in  = out_stat_ff;
      out_last_in  = out_last_ff;
      if (cmd.out_data) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data_ff;
         out_check_in = status.rd_last;
         out_len_in   = held_ff;
         out_stat_in  = 1'b0;
         out_last_in  = status.rd_last;
      end else if (cmd.out_drop) begin
         out_valid_in = 1'b1;
         out_byte_in  = '0;
         out_check_in = 1'b0;
         out_len_in   = held_ff;
         out_stat_in  = 1'b1;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff  <= out_byte_in;
      out_check_ff <= out_check_in;
      out_len_ff   <= out_len_in;
      out_stat_ff  <= out_stat_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_is_check     = out_check_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_status       = out_stat_ff;
   assign rsp_last         = out_last_ff;

endmodule

// File: tb/frame_checker.sv
// ----------------------------------------------------------------------------
// frame_checker: scoreboard for the marked frame deframer
// Watches the csr_, req_ and rsp_ ports at each rising clock edge, keeps
// its own copy of the parser state and the registers, and predicts the
// delivered frame bytes and dropped-frame results. Each accepted result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [mfd_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [mfd_pkg::BYTE_W-1:0]      rsp_out_byte,
   input  logic                            rsp_is_check,
   input  logic [mfd_pkg::LEN_W-1:0]       rsp_frame_length,
   input  logic                            rsp_status,
   input  logic                            rsp_last,
   output int                              error_count,
   output int                              pending
);
   import mfd_pkg::*;

   // shadow parse phases
   localparam logic [STATE_W-1:0] SEEK_MARK   = 3'd0;
   localparam logic [STATE_W-1:0] TAKE_LENGTH = 3'd1;
   localparam logic [STATE_W-1:0] TAKE_DATA   = 3'd2;
   localparam logic [STATE_W-1:0] TAKE_CHECK  = 3'd3;
   localparam logic [STATE_W-1:0] TAKE_END    = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              is_check;
      logic [LEN_W-1:0]  length;
      logic              status;
      logic              last;
   } delivery_type;

   // shadow registers
   logic [BYTE_W-1:0] cfg_mark;
   logic [LEN_W-1:0]  cfg_max_len;

   // shadow parser state
   logic [STATE_W-1:0] phase;
   logic [LEN_W-1:0]   bytes_left;
   logic [LEN_W-1:0]   held_len;
   logic [IDX_W-1:0]   wr_slot;
   logic [BYTE_W-1:0]  frame_store [BUF_DEPTH];

   delivery_type expected_deliveries[$];

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   // compare one accepted result with the oldest prediction
   task automatic check_delivery();
      delivery_type want;
      if (expected_deliveries.size() == 0) begin
         $display("%0t: unexpected result, expected none actual out_byte %0h status %0b",
                  $time, rsp_out_byte, rsp_status);
         error_count++;
      end else begin
         want = expected_deliveries.pop_front();
         check_field("out_byte", want.data, rsp_out_byte);
         check_field("is_check", want.is_check, rsp_is_check);
         check_field("frame_length", want.length, rsp_frame_length);
         check_field("status", want.status, rsp_status);
         check_field("last", want.last, rsp_last);
      end
   endtask

   // advance the shadow parser by one received byte
   task automatic deframe_byte(input logic [BYTE_W-1:0] rx);
      logic [LEN_W-1:0] limit;
      delivery_type     item;
      limit = (cfg_max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_max_len;
      case (phase)
         SEEK_MARK: begin
            if (rx == cfg_mark)
               phase = TAKE_LENGTH;
         end
         TAKE_LENGTH: begin
            // mark-valued or oversize lengths are skipped
            if (rx != cfg_mark && rx <= {2'b00, limit}) begin
               held_len   = rx[LEN_W-1:0];
               bytes_left = rx[LEN_W-1:0];
               wr_slot    = '0;
               phase      = TAKE_DATA;
            end
         end
         TAKE_DATA: begin
            // zero length still takes one data byte
            frame_store[wr_slot] = rx;
            wr_slot = wr_slot + 1'b1;
            if (bytes_left <= 1) begin
               bytes_left = '0;
               phase      = TAKE_CHECK;
            end else begin
               bytes_left = bytes_left - 1'b1;
            end
         end
         TAKE_CHECK: begin
            frame_store[wr_slot] = rx;
            wr_slot = wr_slot + 1'b1;
            phase   = TAKE_END;
         end
         TAKE_END: begin
            if (rx == cfg_mark) begin
               // data bytes in order, then the check byte marked last
               for (int i = 0; i < int'(wr_slot); i++) begin
                  item.data     = frame_store[i];
                  item.is_check = (i + 1 == int'(wr_slot));
                  item.length   = held_len;
                  item.status   = 1'b0;
                  item.last     = (i + 1 == int'(wr_slot));
                  expected_deliveries.push_back(item);
               end
            end else begin
               item.data     = '0;
               item.is_check = 1'b0;
               item.length   = held_len;
               item.status   = 1'b1;
               item.last     = 1'b1;
               expected_deliveries.push_back(item);
            end
            phase = SEEK_MARK;
         end
         default: phase = SEEK_MARK;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_mark    = MARK_BYTE_RESET;
         cfg_max_len = MAX_LENGTH_RESET;
         phase       = SEEK_MARK;
         bytes_left  = '0;
         held_len    = '0;
         wr_slot     = '0;
         error_count = 0;
         expected_deliveries.delete();
      end else begin
         // register writes; spare indexes do nothing
         if (csr_we) begin
            case (csr_index)
               CSR_MARK_BYTE:  cfg_mark = csr_wdata;
               CSR_MAX_LENGTH: cfg_max_len = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall)
            check_delivery();
         if (req_valid && !req_stall)
            deframe_byte(req_in_byte);
      end
      pending = expected_deliveries.size();
   end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the marked frame deframer
// Feeds a short directed byte stream, then random framed traffic (good
// frames, bad end marks, rejected lengths, truncated frames and line noise)
// under several mark and max_length settings, with random gaps on the
// request side and random stalls on the result side. frame_checker does
// the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import mfd_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 8;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = CSR_INDEX_W'(3);

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_in_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_is_check;
   logic [LEN_W-1:0]       rsp_frame_length;
   logic                   rsp_status;
   logic                   rsp_last;

   int error_count;
   int pending;
   int cycle_count = 0;

   // stimulus view of the current settings
   logic [BYTE_W-1:0] cur_mark;
   int                cur_limit;
   int                burst_left = 0;
   int                frame_bytes;

   always #5 clock = ~clock;

   marked_frame_deframer i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_check     (rsp_is_check),
      .rsp_frame_length (rsp_frame_length),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   frame_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_check     (rsp_is_check),
      .rsp_frame_length (rsp_frame_length),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .error_count      (error_count),
      .pending          (pending)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result-side backpressure: open runs, short stalls, rare long stalls
   initial begin : stall_gen
      int pick;
      int span;
      rsp_stall = 1'b0;
      forever begin
         pick = $urandom_range(0, 99);
         @(negedge clock);
         if (pick < 45) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 8);
         end else if (pick < 60) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(20, 80);
         end else if (pick < 90) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 3);
         end else if (pick < 98) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(4, 12);
         end else begin
            rsp_stall <= 1'b1;
            span = $urandom_range(30, 60);
         end
         repeat (span - 1) @(negedge clock);
      end
   end

   // one request transaction; starts and ends at a falling edge
   task automatic send_byte(input logic [BYTE_W-1:0] value, input bit counted);
      int gap;
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            burst_left = $urandom_range(10, 40);
            gap = 0;
         end else if (pick < 50) gap = 0;
         else if (pick < 85) gap = $urandom_range(1, 3);
         else if (pick < 97) gap = $urandom_range(4, 10);
         else gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (counted) frame_bytes++;
   endtask

   // stop feeding and let every predicted result drain
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [BYTE_W-1:0] mark,
                             input logic [CSR_DATA_W-1:0] max_raw);
      write_reg(CSR_MARK_BYTE, mark);
      write_reg(CSR_MAX_LENGTH, max_raw);
      cur_mark  = mark;
      cur_limit = (int'(max_raw[LEN_W-1:0]) > int'(MAX_PAYLOAD)) ?
                  int'(MAX_PAYLOAD) : int'(max_raw[LEN_W-1:0]);
   endtask

   // one frame; forced_len < 0 picks a random length
   task automatic send_frame(input int forced_len, input bit bad_end, input bit truncate);
      int                len;
      int                n_data;
      int                cut;
      int                n_junk;
      logic [BYTE_W-1:0] rx;
      send_byte(cur_mark, 1'b1);
      // rejected length candidates ahead of the real one
      n_junk = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
      for (int j = 0; j < n_junk; j++) begin
         if ($urandom_range(0, 1) == 0) send_byte(cur_mark, 1'b1);
         else send_byte(BYTE_W'($urandom_range(cur_limit + 1, 255)), 1'b1);
      end
      if (forced_len >= 0) len = forced_len;
      else if ($urandom_range(0, 99) < 80)
         len = $urandom_range(0, (cur_limit < 8) ? cur_limit : 8);
      else len = $urandom_range(0, cur_limit);
      while (len == int'(cur_mark)) len = $urandom_range(0, cur_limit);
      send_byte(BYTE_W'(len), 1'b1);
      n_data = (len == 0) ? 1 : len;
      cut = truncate ? $urandom_range(0, n_data - 1) : n_data;
      for (int k = 0; k < cut; k++)
         send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
      if (!truncate) begin
         send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
         rx = BYTE_W'($urandom_range(0, 255));
         if (rx == cur_mark) rx = ~rx;
         send_byte(bad_end ? rx : cur_mark, 1'b1);
      end
   endtask

   // mostly good frames, some broken ones and some line noise
   task automatic random_traffic(input int budget);
      int pick;
      int n_noise;
      logic [BYTE_W-1:0] rx;
      frame_bytes = 0;
      send_frame(cur_limit, 1'b0, 1'b0);
      while (frame_bytes < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) send_frame(-1, 1'b0, 1'b0);
         else if (pick < 85) send_frame(-1, 1'b1, 1'b0);
         else if (pick < 92) send_frame(-1, 1'b0, 1'b1);
         else begin
            n_noise = $urandom_range(1, 4);
            for (int k = 0; k < n_noise; k++) begin
               rx = BYTE_W'($urandom_range(0, 255));
               if ($urandom_range(0, 4) == 0) rx = cur_mark;
               send_byte(rx, 1'b0);
            end
         end
      end
   endtask

   initial begin : stimulus
      logic [BYTE_W-1:0] directed_bytes[$];
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_in_byte = '0;
      cur_mark    = MARK_BYTE_RESET;
      cur_limit   = int'(MAX_LENGTH_RESET);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: idle noise, zero length, skipped lengths with a
      // mark-valued data byte, and a dropped frame
      directed_bytes = '{
         8'h00, 8'hFF,
         MARK_BYTE_RESET, 8'h00, 8'hAA, 8'h55, MARK_BYTE_RESET,
         MARK_BYTE_RESET, MARK_BYTE_RESET, 8'd63, 8'hFF, 8'd1,
         MARK_BYTE_RESET, 8'h00, MARK_BYTE_RESET,
         MARK_BYTE_RESET, 8'd2, 8'h11, 8'h22, 8'h33, 8'h7D
      };
      foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b1);
      drain();

      // mark 0, max_length written all ones (masked, then capped)
      set_config(8'h00, 8'hFF);
      random_traffic(110);
      drain();

      // mark 255, zero max_length
      set_config(8'hFF, 8'h00);
      random_traffic(100);
      drain();

      // random settings; spare indexes must leave the registers alone
      set_config(BYTE_W'($urandom_range(0, 255)),
                 {2'($urandom_range(0, 3)), 6'($urandom_range(1, 62))});
      write_reg(CSR_SPARE_2, CSR_DATA_W'($urandom_range(0, 255)));
      write_reg(CSR_SPARE_3, CSR_DATA_W'($urandom_range(0, 255)));
      random_traffic(110);
      drain();

      // back to the reset settings
      set_config(MARK_BYTE_RESET, CSR_DATA_W'(MAX_LENGTH_RESET));
      random_traffic(110);
      drain();

      repeat (20) @(negedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
rtl/mfd_pkg.sv
rtl/mfd_ctrl.sv
rtl/mfd_dp.sv
rtl/marked_frame_deframer.sv
tb/frame_checker.sv
tb/testbench.sv
